// ===== hw/rtl/lmfr_pkg.sv =====
// ----------------------------------------------------------------------------
// lmfr_pkg: shared types and constants of the LED matrix frame refresh unit
// Holds the beat types, command kinds, sequencer states and the byte
// reversal helper used by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package lmfr_pkg;

  // Default number of driver chips in the chain (legal range 1 to 8).
  localparam int CHIPS_DEFAULT = 4;
  localparam int CHIPS_MAX     = 8;
  localparam int ROWS          = 8;

  // Queue entries hold store addresses sized for the longest chain.
  localparam int StoreAddrW = $clog2(ROWS * CHIPS_MAX);
  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    OP_SET_PIXEL = 2'd0,
    OP_REG_WRITE = 2'd1,
    OP_REFRESH   = 2'd2
  } lmfr_op_e;

  typedef enum logic [1:0] {
    KIND_PIXEL   = 2'd0,
    KIND_REGWR   = 2'd1,
    KIND_REFRESH = 2'd2
  } lmfr_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_PIXEL_WR = 2'd1,
    ST_REGWR    = 2'd2,
    ST_REFRESH  = 2'd3
  } lmfr_state_e;

  // Input beat.
  typedef struct packed {
    logic [1:0] opcode;
    logic [5:0] pixel_x;
    logic [2:0] pixel_y;
    logic       pixel_on;
    logic [3:0] target_chip;
    logic [3:0] reg_addr_in;
    logic [7:0] reg_data_in;
  } lmfr_cmd_t;

  // Output beat.
  typedef struct packed {
    logic [3:0] word_addr;
    logic [7:0] word_data;
    logic       latch_after;
    logic       last_word;
  } lmfr_word_t;

  // Classified command as it travels through the queue.
  typedef struct packed {
    lmfr_kind_e            kind;
    logic [StoreAddrW-1:0] store_addr;
    logic [2:0]            bit_sel;
    logic                  pixel_on;
    logic [3:0]            target_chip;
    logic [3:0]            reg_addr;
    logic [7:0]            reg_data;
  } lmfr_entry_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = v[7-k];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/led_matrix_frame_refresh_unit.sv =====
// ----------------------------------------------------------------------------
// led_matrix_frame_refresh_unit: LED matrix chain frame buffer and sequencer
// A command is registered in the queue, the sequencer state and the word stage
// before its first word appears, and waits in the queue behind earlier commands.
// The sequencer emits one word per cycle while in register write or refresh.
// busy is high while the two-entry command queue is full.
// Reset clears rotate_mode and the frame store (per-byte valid bits), at once.
// ----------------------------------------------------------------------------
//
// Structure
//   The front end classifies every accepted command beat: set pixel gets its
//   frame store byte address and bit resolved here, and commands that change
//   nothing (a column beyond the chain, the unused opcode) are dropped. Kept
//   commands enter a short queue, so a new command can be accepted while a
//   long refresh is still streaming.
//
//   The back end pops one command at a time and runs it to completion. Set
//   pixel is a read-modify-write of one store byte, written in the pixel
//   write state. Register write sends one word per chip, with the register
//   address only for the target chip (or all chips on a broadcast). Refresh
//   reads the store one byte per cycle and sends eight row groups of CHIPS
//   words; in rotated mode the rows are flipped and each byte is bit-reversed.
//
//   Every command, including set pixel, goes through the queue, so store
//   updates and refresh reads happen in the order the commands were given.
//
// Output
//   A result beat is shown for one cycle with word_valid_o high; the receiver
//   must take it in that cycle.
//
// Configuration
//   Register 0 at byte address 0: bit 0 is rotate_mode. Write it only while
//   the unit is idle; the unit itself does not enforce this.
// ----------------------------------------------------------------------------
module led_matrix_frame_refresh_unit #(
  parameter int CHIPS = lmfr_pkg::CHIPS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Command channel
  input  logic                 start,
  output logic                 busy,
  input  lmfr_pkg::lmfr_cmd_t  cmd_i,
  // Word channel
  output logic                 word_valid_o,
  output lmfr_pkg::lmfr_word_t word_o,
  // Configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic                  accept;
  logic                  push;
  logic                  pop;
  logic                  q_empty;
  logic                  q_full;
  lmfr_pkg::lmfr_entry_t push_entry;
  lmfr_pkg::lmfr_entry_t head_entry;
  logic                  rotate_q;
  logic                  cfg_write;
  logic                  sel_rotate;

  // A command beat is taken whenever the queue has room.
  assign busy   = q_full;
  assign accept = start && !busy;

  // Registers sit at word addresses; only register 0 exists.
  assign pready     = 1'b1;
  assign sel_rotate = (paddr[2] == 1'b0);
  assign cfg_write  = psel && penable && pwrite && pready;
  assign prdata     = sel_rotate ? {31'd0, rotate_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotate_q <= 1'b0;
    end else if (cfg_write && sel_rotate) begin
      rotate_q <= pwdata[0];
    end
  end

  lmfr_front #(
    .CHIPS(CHIPS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .cmd_i   (cmd_i),
    .push_o  (push),
    .entry_o (push_entry)
  );

  lmfr_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .pop_i  (pop),
    .head_o (head_entry),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  lmfr_back #(
    .CHIPS(CHIPS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rotate_i    (rotate_q),
    .head_i      (head_entry),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .word_o      (word_o),
    .word_valid_o(word_valid_o)
  );

endmodule

// ===== hw/rtl/lmfr_front.sv =====
// ----------------------------------------------------------------------------
// lmfr_front: command classifier
// Turns an accepted input beat into a queue entry, resolves the frame store
// address and bit of a set pixel, and drops commands that change nothing.
// ----------------------------------------------------------------------------
module lmfr_front #(
  parameter int CHIPS = lmfr_pkg::CHIPS_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  lmfr_pkg::lmfr_cmd_t cmd_i,
  output logic                push_o,
  output lmfr_pkg::lmfr_entry_t entry_o
);

  localparam int AddrW = $clog2(lmfr_pkg::ROWS * CHIPS);

  logic [AddrW-1:0] px;
  logic [AddrW-1:0] py_base;
  logic [AddrW-1:0] store_addr;
  logic             x_in_range;
  logic             keep;
  logic             accept_seen_q;

  // Columns are mirrored: column 0 lands in the top bit of the last chip.
  assign x_in_range = {1'b0, cmd_i.pixel_x} < 7'(lmfr_pkg::ROWS * CHIPS);
  assign px         = AddrW'(lmfr_pkg::ROWS * CHIPS - 1) - cmd_i.pixel_x[AddrW-1:0];
  assign py_base    = AddrW'((3'd7 - cmd_i.pixel_y) * CHIPS);
  assign store_addr = (px >> 3) + py_base;

  always_comb begin
    entry_o             = '0;
    entry_o.store_addr  = lmfr_pkg::StoreAddrW'(store_addr);
    entry_o.bit_sel     = px[2:0];
    entry_o.pixel_on    = cmd_i.pixel_on;
    entry_o.target_chip = cmd_i.target_chip;
    entry_o.reg_addr    = cmd_i.reg_addr_in;
    entry_o.reg_data    = cmd_i.reg_data_in;
    keep                = 1'b0;
    case (cmd_i.opcode)
      lmfr_pkg::OP_SET_PIXEL: begin
        entry_o.kind = lmfr_pkg::KIND_PIXEL;
        keep         = x_in_range;
      end
      lmfr_pkg::OP_REG_WRITE: begin
        entry_o.kind = lmfr_pkg::KIND_REGWR;
        keep         = 1'b1;
      end
      lmfr_pkg::OP_REFRESH: begin
        entry_o.kind = lmfr_pkg::KIND_REFRESH;
        keep         = 1'b1;
      end
      default: begin
        entry_o.kind = lmfr_pkg::KIND_PIXEL;
        keep         = 1'b0;
      end
    endcase
  end

  assign push_o = accept_i && keep;

  // Tracks the previous acceptance for the check below.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accept_seen_q <= 1'b0;
    end else begin
      accept_seen_q <= accept_i;
    end
  end

  // A push only ever follows from an accepted beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_o |-> accept_i)
    else $error("lmfr_front: push without an accepted beat");

  // An out-of-range column never reaches the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && (entry_o.kind == lmfr_pkg::KIND_PIXEL)) |-> x_in_range)
    else $error("lmfr_front: out-of-range pixel pushed");

  // When the previous acceptance is seen, a pushed set pixel's store address stays inside the frame store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_seen_q && push_o && (entry_o.kind == lmfr_pkg::KIND_PIXEL)) |->
      ({1'b0, store_addr} < (AddrW + 1)'(lmfr_pkg::ROWS * CHIPS)))
    else $error("lmfr_front: pixel address beyond frame store");

endmodule

// ===== hw/rtl/lmfr_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// lmfr_cmd_fifo: command queue
// Short queue of classified commands between the front end and the back
// end sequencer.
// ----------------------------------------------------------------------------
module lmfr_cmd_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  lmfr_pkg::lmfr_entry_t entry_i,
  input  logic                  pop_i,
  output lmfr_pkg::lmfr_entry_t head_o,
  output logic                  empty_o,
  output logic                  full_o
);

  localparam int PtrW = (lmfr_pkg::QueueDepth > 1) ? $clog2(lmfr_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(lmfr_pkg::QueueDepth + 1);

  lmfr_pkg::lmfr_entry_t slots_q [lmfr_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(lmfr_pkg::QueueDepth));
  assign head_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(lmfr_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(lmfr_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== hw/rtl/lmfr_back.sv =====
// ----------------------------------------------------------------------------
// lmfr_back: frame store and word sequencer
// Executes queued commands in order: updates the frame store for set pixel,
// and streams register write and refresh words to the chain.
// ----------------------------------------------------------------------------
module lmfr_back #(
  parameter int CHIPS = lmfr_pkg::CHIPS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rotate_i,
  input  lmfr_pkg::lmfr_entry_t head_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  output lmfr_pkg::lmfr_word_t  word_o,
  output logic                  word_valid_o
);

  localparam int Depth = lmfr_pkg::ROWS * CHIPS;
  localparam int AddrW = $clog2(Depth);
  localparam int ChipW = (CHIPS > 1) ? $clog2(CHIPS) : 1;

  lmfr_pkg::lmfr_state_e state_q, state_d;
  lmfr_pkg::lmfr_entry_t cmd_q, cmd_d;
  logic [2:0]       row_q, row_d;
  logic [ChipW-1:0] chip_q, chip_d;

  // Frame store with one valid bit per byte; an unwritten byte reads as zero.
  logic [7:0]       frame_mem [Depth];
  logic [Depth-1:0] vld_q;
  logic [7:0]       rd_data_q;
  logic             rd_vld_q;
  logic [AddrW-1:0] rd_addr;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic [7:0]       old_byte;

  // Word stage: one beat in flight toward the outputs.
  logic       s1_valid_q, s1_valid_d;
  logic [3:0] s1_addr_q, s1_addr_d;
  logic [7:0] s1_data_q, s1_data_d;
  logic       s1_latch_q, s1_latch_d;
  logic       s1_last_q, s1_last_d;
  logic       s1_mem_q, s1_mem_d;
  logic       s1_rev_q, s1_rev_d;

  logic       last_chip;
  logic       bcast;
  logic       chip_hit;
  logic [7:0] mem_byte;

  assign last_chip = (chip_q == ChipW'(CHIPS - 1));
  assign bcast     = cmd_q.target_chip > 4'(CHIPS);
  assign chip_hit  = (5'(cmd_q.target_chip) + 5'(chip_q)) == 5'(CHIPS);
  assign old_byte  = rd_vld_q ? rd_data_q : 8'h00;

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    row_d      = row_q;
    chip_d     = chip_q;
    pop_o      = 1'b0;
    rd_addr    = head_i.store_addr[AddrW-1:0];
    wr_en      = 1'b0;
    wr_addr    = cmd_q.store_addr[AddrW-1:0];
    wr_data    = old_byte;
    wr_data[cmd_q.bit_sel] = cmd_q.pixel_on;
    s1_valid_d = 1'b0;
    s1_addr_d  = cmd_q.reg_addr;
    s1_data_d  = cmd_q.reg_data;
    s1_latch_d = last_chip;
    s1_last_d  = 1'b0;
    s1_mem_d   = 1'b0;
    s1_rev_d   = 1'b0;
    case (state_q)
      lmfr_pkg::ST_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          cmd_d  = head_i;
          row_d  = '0;
          chip_d = '0;
          case (head_i.kind)
            lmfr_pkg::KIND_PIXEL:   state_d = lmfr_pkg::ST_PIXEL_WR;
            lmfr_pkg::KIND_REGWR:   state_d = lmfr_pkg::ST_REGWR;
            lmfr_pkg::KIND_REFRESH: state_d = lmfr_pkg::ST_REFRESH;
            default:                state_d = lmfr_pkg::ST_IDLE;
          endcase
        end
      end
      lmfr_pkg::ST_PIXEL_WR: begin
        // The byte read while popping is now in rd_data_q.
        wr_en   = 1'b1;
        state_d = lmfr_pkg::ST_IDLE;
      end
      lmfr_pkg::ST_REGWR: begin
        s1_valid_d = 1'b1;
        s1_addr_d  = (bcast || chip_hit) ? cmd_q.reg_addr : 4'd0;
        s1_last_d  = last_chip;
        chip_d     = chip_q + 1'b1;
        if (last_chip) begin
          chip_d  = '0;
          state_d = lmfr_pkg::ST_IDLE;
        end
      end
      lmfr_pkg::ST_REFRESH: begin
        if (rotate_i) begin
          rd_addr = AddrW'((3'd7 - row_q) * CHIPS) + AddrW'(chip_q);
        end else begin
          rd_addr = AddrW'(row_q * CHIPS) + (AddrW'(CHIPS - 1) - AddrW'(chip_q));
        end
        s1_valid_d = 1'b1;
        s1_addr_d  = 4'(row_q) + 4'd1;
        s1_last_d  = last_chip && (row_q == 3'(lmfr_pkg::ROWS - 1));
        s1_mem_d   = 1'b1;
        s1_rev_d   = rotate_i;
        chip_d     = chip_q + 1'b1;
        if (last_chip) begin
          chip_d = '0;
          row_d  = row_q + 1'b1;
          if (row_q == 3'(lmfr_pkg::ROWS - 1)) begin
            state_d = lmfr_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = lmfr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lmfr_pkg::ST_IDLE;
      row_q      <= '0;
      chip_q     <= '0;
      s1_valid_q <= 1'b0;
      vld_q      <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      row_q      <= row_d;
      chip_q     <= chip_d;
      s1_valid_q <= s1_valid_d;
      rd_vld_q   <= vld_q[rd_addr];
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    s1_addr_q  <= s1_addr_d;
    s1_data_q  <= s1_data_d;
    s1_latch_q <= s1_latch_d;
    s1_last_q  <= s1_last_d;
    s1_mem_q   <= s1_mem_d;
    s1_rev_q   <= s1_rev_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      frame_mem[wr_addr] <= wr_data;
    end
    rd_data_q <= frame_mem[rd_addr];
  end

  assign mem_byte = s1_rev_q ? lmfr_pkg::rev8(old_byte) : old_byte;

  always_comb begin
    word_o.word_addr   = s1_addr_q;
    word_o.word_data   = s1_mem_q ? mem_byte : s1_data_q;
    word_o.latch_after = s1_latch_q;
    word_o.last_word   = s1_last_q;
  end

  assign word_valid_o = s1_valid_q;

  // A word only follows a cycle spent in a word-emitting state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> ($past(state_q) == lmfr_pkg::ST_REGWR ||
                    $past(state_q) == lmfr_pkg::ST_REFRESH))
    else $error("lmfr_back: word without an emitting state");

  // The final word of a command also closes its chain group.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word_valid_o && word_o.last_word) |-> word_o.latch_after)
    else $error("lmfr_back: last word without latch");

  // The pixel write state is always followed by idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lmfr_pkg::ST_PIXEL_WR) |=> (state_q == lmfr_pkg::ST_IDLE))
    else $error("lmfr_back: pixel write did not return to idle");

  // The queue is only popped from idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == lmfr_pkg::ST_IDLE && !empty_i))
    else $error("lmfr_back: pop outside idle");

endmodule
